[src/isl_pkg.sv]
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and constants of the indexed shift list: field widths,
// operation codes, status codes and the control group sent to every cell.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic app;
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

[src/isl_cell.sv]
// ----------------------------------------------------------------------------
// isl_cell
// One entry of the list. It holds a word, takes its left or right
// neighbour's word when the list shifts, and offers its word for reads.
// ----------------------------------------------------------------------------
module isl_cell
    import isl_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [CMP_W-1:0]      i_pos,
    input  logic [CMP_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  at_pos;

    assign at_pos = (IDX == i_pos);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.app && (IDX == i_count)) begin
            n_data = i_value;
        end else if (i_ctrl.ins && at_pos) begin
            n_data = i_value;
        end else if (i_ctrl.ins && (IDX > i_pos)) begin
            n_data = i_left;
        end else if (i_ctrl.rem && (IDX >= i_pos)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = {DATA_WIDTH{at_pos}} & r_data;

endmodule

[src/indexed_shift_list.sv]
// ----------------------------------------------------------------------------
// indexed_shift_list
// Ordered list of signed words with append, insert, read and remove by index.
// ----------------------------------------------------------------------------
// The s_axis channel carries one operation per transfer and the m_axis
// channel returns exactly one result per operation, in order. Each result
// gives the status, the read value (all ones unless a read succeeds) and the
// entry count after the operation.
// An input transfer's result is registered and shows on m_axis in the next
// cycle. The block takes one operation in every cycle unless m_axis stalls:
// all entries sit in a chain of cells that shift up or down together, and a
// read picks among the first min(CAPACITY, 32) cells, all a 5-bit pos reaches.
// A result waits in the output register while m_axis_tready is low; a new
// input is taken in the same cycle that the waiting result is taken, so a
// stalled receiver stalls the sender with no extra bubble.
// Reset empties the list and drops any pending result. Entry contents are
// not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_shift_list
    import isl_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // operation, position, item_value
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // status, read_value, count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RSPAN = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic                         accept;
    t_op                          op;
    logic [CMP_W-1:0]             pos;
    logic [CMP_W-1:0]             cnt;
    logic signed [ITEM_W-1:0]     item;
    logic signed [DATA_WIDTH-1:0] wr_value;
    logic signed [DATA_WIDTH-1:0] rd_or;
    logic [STATUS_W-1:0]          status;
    logic signed [ITEM_W-1:0]     rd_value;
    t_cell_ctrl                   ctrl;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [RSPAN];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign op       = t_op'(s_axis_tdata[OP_W-1:0]);
    assign pos      = CMP_W'(s_axis_tdata[OP_W +: POS_W]);
    assign item     = s_axis_tdata[OP_W+POS_W +: ITEM_W];
    assign cnt      = CMP_W'(r_count);
    assign wr_value = DATA_WIDTH'(item);

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < RSPAN; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_comb begin
        status   = ST_OK;
        rd_value = '1;
        ctrl     = '0;
        n_count  = r_count;
        case (op)
            OP_APPEND: begin
                if (cnt == CAP_C) begin
                    status = ST_FULL;
                end else begin
                    ctrl.app = accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (pos > cnt) begin
                    status = ST_RANGE;
                end else if (cnt == CAP_C) begin
                    status = ST_FULL;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_READ: begin
                if (pos >= cnt) begin
                    status = ST_RANGE;
                end else begin
                    rd_value = ITEM_W'(rd_or);
                end
            end
            OP_REMOVE: begin
                if (pos >= cnt) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.rem = accept;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = cell_data[g+1];
        end

        if (g < RSPAN) begin : g_rd
            isl_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .INDEX      (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_pos     (pos),
                .i_count   (cnt),
                .i_value   (wr_value),
                .i_left    (left),
                .i_right   (right),
                .o_data    (cell_data[g]),
                .o_rd_data (cell_rd[g])
            );
        end else begin : g_nord
            isl_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .INDEX      (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_pos     (pos),
                .i_count   (cnt),
                .i_value   (wr_value),
                .i_left    (left),
                .i_right   (right),
                .o_data    (cell_data[g]),
                .o_rd_data ()
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {1'b0, COUNT_W'(n_count), rd_value, status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[src/isl_checker.sv]
// ----------------------------------------------------------------------------
// isl_checker
// Port-level checks of the indexed shift list, bound to the top level.
// ----------------------------------------------------------------------------
module isl_checker
    import isl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam int CAP_CNT = (CAPACITY > 31) ? 31 : CAPACITY;

    logic [STATUS_W-1:0] st;
    logic [ITEM_W-1:0]   rd;
    logic [COUNT_W-1:0]  cnt;

    assign st  = m_axis_tdata[STATUS_W-1:0];
    assign rd  = m_axis_tdata[STATUS_W +: ITEM_W];
    assign cnt = m_axis_tdata[STATUS_W+ITEM_W +: COUNT_W];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted operation gave no result in the next cycle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or vanished");

    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (st != ST_OK) |-> (rd == '1))
        else $error("failed operation returned a read value other than all ones");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (CAPACITY < 32) |-> (cnt <= COUNT_W'(CAP_CNT)))
        else $error("count above capacity");

endmodule

bind indexed_shift_list isl_checker #(
    .CAPACITY (CAPACITY)
) u_isl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/indexed_shift_list_tb.sv]
// ----------------------------------------------------------------------------
// indexed_shift_list_tb
// Self-checking testbench for the indexed shift list. A directed table covers
// the empty and full list, the field extremes and the index errors. A long
// random run follows, which swings the list between empty and full. Every
// result is checked field by field against its table row or a shadow list copy.
// ----------------------------------------------------------------------------
module indexed_shift_list_tb;
    import isl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 16;
    localparam int RANDOM_OPS  = 1450;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [COUNT_W-1:0]  cnt;
        logic [ITEM_W-1:0]   rd;
        logic [STATUS_W-1:0] status;
    } t_list_reply;

    typedef struct {
        t_op                 op;
        int                  pos;
        logic [ITEM_W-1:0]   val;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] st;
        logic [ITEM_W-1:0]   rd;
        int                  cnt;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // operation, position, item_value, zero pad
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // status, read_value, count, zero pad

    logic [ITEM_W-1:0] shadow_list [LIST_DEPTH];
    int                shadow_cnt;
    t_list_reply       pending_replies [$];
    int                errors;
    bit                hold_req;
    bit                growing;

    t_dir_row directed_rows [22] = '{
        '{OP_READ,    0, 32'h0000_0000,  1, 1, ST_RANGE, 32'hFFFF_FFFF,  0},
        '{OP_REMOVE,  0, 32'h0000_0000,  1, 1, ST_RANGE, 32'hFFFF_FFFF,  0},
        '{OP_INSERT,  1, 32'h0000_0005,  1, 1, ST_RANGE, 32'hFFFF_FFFF,  0},
        '{OP_APPEND, 31, 32'h8000_0000,  1, 1, ST_OK,    32'hFFFF_FFFF,  1},
        '{OP_INSERT,  0, 32'h7FFF_FFFF,  1, 1, ST_OK,    32'hFFFF_FFFF,  2},
        '{OP_READ,    0, 32'h0000_0000,  1, 1, ST_OK,    32'h7FFF_FFFF,  2},
        '{OP_READ,    1, 32'hFFFF_FFFF,  1, 1, ST_OK,    32'h8000_0000,  2},
        '{OP_INSERT,  2, 32'hFFFF_FFFF,  1, 1, ST_OK,    32'hFFFF_FFFF,  3},
        '{OP_INSERT,  1, 32'h0000_0000,  1, 0, ST_OK,    32'h0,          0},
        '{OP_REMOVE,  0, 32'h0000_0000,  1, 0, ST_OK,    32'h0,          0},
        '{OP_READ,    3, 32'h0000_0000,  1, 1, ST_RANGE, 32'hFFFF_FFFF,  3},
        '{OP_APPEND,  0, 32'h1234_5678, 13, 0, ST_OK,    32'h0,          0},
        '{OP_APPEND,  7, 32'h0000_0001,  1, 1, ST_FULL,  32'hFFFF_FFFF, 16},
        '{OP_INSERT, 16, 32'h0000_0002,  1, 1, ST_FULL,  32'hFFFF_FFFF, 16},
        '{OP_INSERT, 17, 32'h0000_0002,  1, 1, ST_RANGE, 32'hFFFF_FFFF, 16},
        '{OP_READ,   15, 32'h0000_0000,  1, 0, ST_OK,    32'h0,          0},
        '{OP_READ,   16, 32'h0000_0000,  1, 1, ST_RANGE, 32'hFFFF_FFFF, 16},
        '{OP_REMOVE, 31, 32'h0000_0000,  1, 1, ST_RANGE, 32'hFFFF_FFFF, 16},
        '{OP_REMOVE, 15, 32'h0000_0000,  1, 0, ST_OK,    32'h0,          0},
        '{OP_REMOVE,  7, 32'h0000_0000,  1, 0, ST_OK,    32'h0,          0},
        '{OP_INSERT,  0, 32'hA5A5_5A5A,  1, 0, ST_OK,    32'h0,          0},
        '{OP_READ,    5, 32'h0000_0000,  1, 0, ST_OK,    32'h0,          0}
    };

    indexed_shift_list #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (ITEM_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_list_reply apply_list_op(t_op op, int pos, logic [ITEM_W-1:0] val);
        t_list_reply r;
        r.status = ST_OK;
        r.rd     = '1;
        case (op)
            OP_APPEND: begin
                if (shadow_cnt >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_list[shadow_cnt] = val;
                    shadow_cnt++;
                end
            end
            OP_INSERT: begin
                if (pos > shadow_cnt) begin
                    r.status = ST_RANGE;
                end else if (shadow_cnt >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_cnt; i > pos; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_cnt++;
                end
            end
            OP_READ: begin
                if (pos >= shadow_cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    r.rd = shadow_list[pos];
                end
            end
            default: begin
                if (pos >= shadow_cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < shadow_cnt; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_cnt--;
                end
            end
        endcase
        r.cnt = shadow_cnt[COUNT_W-1:0];
        return r;
    endfunction

    // Offers one operation and returns at the edge where it is accepted. The
    // valid stays high, so a following call offers its operation with no gap.
    task automatic offer_op(t_op op, int pos, logic [ITEM_W-1:0] val, bit typed,
                            t_list_reply typed_reply);
        t_list_reply r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, pos[POS_W-1:0], op};
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_list_op(op, pos, val);
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    function automatic logic [ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        t_list_reply       typed_reply;
        t_op               op;
        int                pos;
        int                roll;
        int                burst_left;
        logic [ITEM_W-1:0] val;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        shadow_cnt    = 0;
        errors        = 0;
        hold_req      = 1'b0;
        growing       = 1'b1;
        burst_left    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            typed_reply.status = directed_rows[n].st;
            typed_reply.rd     = directed_rows[n].rd;
            typed_reply.cnt    = directed_rows[n].cnt[COUNT_W-1:0];
            for (int k = 0; k < directed_rows[n].reps; k++) begin
                offer_op(directed_rows[n].op, directed_rows[n].pos,
                         directed_rows[n].val + k, directed_rows[n].typed, typed_reply);
            end
        end

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            burst_left--;
            if (n == 300 || n == 1100) hold_req = 1'b1;
            if (n == 700) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_replies.size() != 0) @(posedge i_clk);
            end

            if (shadow_cnt == LIST_DEPTH) growing = 1'b0;
            if (shadow_cnt == 0) growing = 1'b1;
            if ($urandom_range(0, 40) == 0) growing = !growing;

            roll = $urandom_range(0, 99);
            val  = pick_value();
            if (roll < 10) begin
                op  = t_op'($urandom_range(0, 3));
                pos = $urandom_range(0, 31);
            end else begin
                roll = $urandom_range(0, 99);
                if (growing) begin
                    op = roll < 35 ? OP_APPEND : roll < 70 ? OP_INSERT :
                         roll < 85 ? OP_READ : OP_REMOVE;
                end else begin
                    op = roll < 15 ? OP_APPEND : roll < 30 ? OP_INSERT :
                         roll < 50 ? OP_READ : OP_REMOVE;
                end
                if (op == OP_INSERT || shadow_cnt == 0) begin
                    pos = $urandom_range(0, shadow_cnt);
                end else begin
                    pos = $urandom_range(0, shadow_cnt - 1);
                end
                if (op == OP_APPEND) pos = $urandom_range(0, 31);
            end
            typed_reply = '0;
            offer_op(op, pos, val, 1'b0, typed_reply);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : receiver
        int          mode;
        logic [31:0] mask;
        m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            mask = $urandom;
            for (int k = 0; k < 32; k++) begin
                @(posedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= mask[k];
                        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= mask[k] | mask[(k + 7) % 32];
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[STATUS_W+ITEM_W+COUNT_W-1:0];
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got %h", $time, got);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.rd !== want.rd) begin
                    $display("%0t: read value expected %h, got %h", $time, want.rd, got.rd);
                    errors++;
                end
                if (got.cnt !== want.cnt) begin
                    $display("%0t: count expected %0d, got %0d", $time, want.cnt, got.cnt);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
